FILE: rtl/core/hsvp_pkg.sv
// ----------------------------------------------------------------------------
// hsvp_pkg: shared types and constants of the HSV palette to RGB565 block
// Role and scheme codes, register indexes, per-scheme tables and the
// queue entry that passes from the front end to the conversion pipeline.
// ----------------------------------------------------------------------------
package hsvp_pkg;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_BASE_HUE    = 2'd0;
  localparam logic [1:0] REG_BASE_SAT    = 2'd1;
  localparam logic [1:0] REG_BASE_VAL    = 2'd2;
  localparam logic [1:0] REG_SCHEME_TYPE = 2'd3;

  // Palette roles
  localparam logic [3:0] ROLE_TEXT    = 4'd0;
  localparam logic [3:0] ROLE_DIM     = 4'd1;
  localparam logic [3:0] ROLE_MUTED   = 4'd2;
  localparam logic [3:0] ROLE_ACCENT  = 4'd3;
  localparam logic [3:0] ROLE_INFO    = 4'd4;
  localparam logic [3:0] ROLE_PRIMARY = 4'd5;
  localparam logic [3:0] ROLE_ERROR   = 4'd9;

  // Scheme codes (only mono is tested by name; others index the tables)
  localparam logic [2:0] SCHEME_MONO = 3'd0;

  localparam logic [8:0] HUE_FULL   = 9'd360;
  localparam logic [6:0] PCT_FULL   = 7'd100;

  typedef struct packed {
    logic [8:0] base_hue;
    logic [7:0] base_sat;
    logic [7:0] base_val;
    logic [2:0] scheme_type;
  } cfg_t;

  // One queued transaction: final hue, saturation and value still scaled by
  // their percent, and a flag for role codes without a palette entry.
  typedef struct packed {
    logic [8:0]  hue;
    logic [14:0] sat_prod;
    logic [14:0] val_prod;
    logic        blank;
  } item_t;

  // Per scheme, per role primary..error
  localparam logic [8:0] HUE_OFF [8][5] = '{
    '{9'd0, 9'd0,   9'd0,   9'd0,   9'd0  },
    '{9'd0, 9'd30,  9'd330, 9'd60,  9'd300},
    '{9'd0, 9'd180, 9'd180, 9'd30,  9'd180},
    '{9'd0, 9'd120, 9'd240, 9'd120, 9'd240},
    '{9'd0, 9'd150, 9'd210, 9'd150, 9'd210},
    '{9'd0, 9'd180, 9'd90,  9'd270, 9'd180},
    '{9'd0, 9'd0,   9'd0,   9'd0,   9'd0  },
    '{9'd0, 9'd0,   9'd0,   9'd0,   9'd0  }
  };

  localparam logic [6:0] SAT_PCT [8][5] = '{
    '{7'd100, 7'd70,  7'd60,  7'd100, 7'd100},
    '{7'd100, 7'd100, 7'd100, 7'd100, 7'd100},
    '{7'd100, 7'd100, 7'd70,  7'd100, 7'd100},
    '{7'd100, 7'd100, 7'd100, 7'd80,  7'd100},
    '{7'd100, 7'd100, 7'd100, 7'd80,  7'd100},
    '{7'd100, 7'd100, 7'd100, 7'd100, 7'd100},
    '{7'd100, 7'd100, 7'd100, 7'd100, 7'd100},
    '{7'd100, 7'd100, 7'd100, 7'd100, 7'd100}
  };

  localparam logic [6:0] VAL_PCT [8][5] = '{
    '{7'd100, 7'd100, 7'd85,  7'd75,  7'd55 },
    '{7'd100, 7'd100, 7'd100, 7'd100, 7'd85 },
    '{7'd100, 7'd100, 7'd100, 7'd100, 7'd100},
    '{7'd100, 7'd100, 7'd100, 7'd100, 7'd85 },
    '{7'd100, 7'd100, 7'd100, 7'd90,  7'd100},
    '{7'd100, 7'd100, 7'd100, 7'd100, 7'd90 },
    '{7'd100, 7'd100, 7'd100, 7'd100, 7'd100},
    '{7'd100, 7'd100, 7'd100, 7'd100, 7'd100}
  };

endpackage

FILE: rtl/core/hsvp_front.sv
// ----------------------------------------------------------------------------
// hsvp_front: role classification
// Picks hue offset and saturation/value percents for the requested role
// and forms the queue entry.
// ----------------------------------------------------------------------------
module hsvp_front
  import hsvp_pkg::*;
(
  input  logic [3:0] role,
  input  cfg_t       cfg,
  output item_t      item
);

  logic [8:0] hue_base;
  logic [8:0] hue_src;
  logic [8:0] hue_off;
  logic [9:0] hue_sum;
  logic [7:0] sat_in;
  logic [7:0] val_in;
  logic [6:0] sat_pct;
  logic [6:0] val_pct;
  logic [2:0] tab_idx;
  logic       blank;

  assign tab_idx = 3'(role - ROLE_PRIMARY);

  always_comb begin
    hue_base = (cfg.base_hue >= HUE_FULL) ? 9'(cfg.base_hue - HUE_FULL) : cfg.base_hue;
    hue_src  = hue_base;
    hue_off  = '0;
    sat_in   = cfg.base_sat;
    val_in   = cfg.base_val;
    sat_pct  = PCT_FULL;
    val_pct  = PCT_FULL;
    blank    = 1'b0;
    priority if (role == ROLE_TEXT) begin
      hue_src = '0;
      sat_in  = 8'd0;
      val_in  = 8'd255;
    end else if (role == ROLE_DIM) begin
      sat_in = 8'd40;
      val_in = 8'd170;
    end else if (role == ROLE_MUTED) begin
      sat_in = 8'd30;
      val_in = 8'd70;
    end else if (role == ROLE_ACCENT) begin
      val_in = (cfg.base_val > 8'd235) ? 8'd255 : 8'(cfg.base_val + 8'd20);
    end else if (role == ROLE_INFO) begin
      if (cfg.scheme_type == SCHEME_MONO) begin
        sat_pct = 7'd50;
      end else begin
        hue_off = 9'd180;
        sat_pct = 7'd70;
        val_pct = 7'd90;
      end
    end else if (role <= ROLE_ERROR) begin
      hue_off = HUE_OFF[cfg.scheme_type][tab_idx];
      sat_pct = SAT_PCT[cfg.scheme_type][tab_idx];
      val_pct = VAL_PCT[cfg.scheme_type][tab_idx];
    end else begin
      blank = 1'b1;
    end

    hue_sum       = {1'b0, hue_src} + {1'b0, hue_off};
    item.hue      = (hue_sum >= {1'b0, HUE_FULL}) ? 9'(hue_sum - {1'b0, HUE_FULL})
                                                  : hue_sum[8:0];
    item.sat_prod = 15'(sat_in) * 15'(sat_pct);
    item.val_prod = 15'(val_in) * 15'(val_pct);
    item.blank    = blank;
  end

endmodule

FILE: rtl/core/hsvp_queue.sv
// ----------------------------------------------------------------------------
// hsvp_queue: small register queue
// Decouples the front end from the conversion pipeline.
// ----------------------------------------------------------------------------
module hsvp_queue
  import hsvp_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  output logic  not_empty,
  input  logic  pop,
  output item_t pop_item
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  item_t             entries [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;

  assign full      = (count == CNT_W'(DEPTH));
  assign not_empty = (count != '0);
  assign pop_item  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : PTR_W'(wr_ptr + 1'b1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : PTR_W'(rd_ptr + 1'b1);
      end
      if (push && !pop) begin
        count <= CNT_W'(count + 1'b1);
      end else if (pop && !push) begin
        count <= CNT_W'(count - 1'b1);
      end
    end
  end

endmodule

FILE: rtl/core/hsvp_back.sv
// ----------------------------------------------------------------------------
// hsvp_back: HSV to RGB565 conversion pipeline
// Five stages: percent scaling and sector split, saturation products,
// divide by 255, value products, divide by 255 with channel select and pack.
// ----------------------------------------------------------------------------
module hsvp_back
  import hsvp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  item_t       in_item,
  output logic        in_take,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] color_565
);

  localparam logic [12:0] RECIP100 = 13'd5243;   // ceil(2^19 / 100)
  localparam logic [16:0] RECIP255 = 17'd65794;  // ceil(2^24 / 255)

  localparam logic [2:0] SEC0 = 3'd0;
  localparam logic [2:0] SEC1 = 3'd1;
  localparam logic [2:0] SEC2 = 3'd2;
  localparam logic [2:0] SEC3 = 3'd3;
  localparam logic [2:0] SEC4 = 3'd4;
  localparam logic [2:0] SEC5 = 3'd5;

  function automatic logic [7:0] div255(input logic [15:0] n);
    logic [32:0] prod;
    prod = 33'(n) * 33'(RECIP255);
    return prod[31:24];
  endfunction

  // stage valid bits and advance enables
  logic v1, v2, v3, v4, v5;
  logic en1, en2, en3, en4, en5;

  assign en5     = !v5 || out_ready;
  assign en4     = !v4 || en5;
  assign en3     = !v3 || en4;
  assign en2     = !v2 || en3;
  assign en1     = !v1 || en2;
  assign in_take = in_valid && en1;

  // stage 1: scale by percent, split hue into sector and fraction
  logic [27:0] sat_mul;
  logic [27:0] val_mul;
  logic [8:0]  sec_base;
  logic [2:0]  sec_c;
  logic [5:0]  rem_c;
  logic [9:0]  frac_mul;
  logic [7:0]  s1_sat, s1_val, s1_frac;
  logic [2:0]  s1_sector;
  logic        s1_blank;

  always_comb begin
    sat_mul = 28'(in_item.sat_prod) * 28'(RECIP100);
    val_mul = 28'(in_item.val_prod) * 28'(RECIP100);
    priority if (in_item.hue >= 9'd300) begin
      sec_c = SEC5; sec_base = 9'd300;
    end else if (in_item.hue >= 9'd240) begin
      sec_c = SEC4; sec_base = 9'd240;
    end else if (in_item.hue >= 9'd180) begin
      sec_c = SEC3; sec_base = 9'd180;
    end else if (in_item.hue >= 9'd120) begin
      sec_c = SEC2; sec_base = 9'd120;
    end else if (in_item.hue >= 9'd60) begin
      sec_c = SEC1; sec_base = 9'd60;
    end else begin
      sec_c = SEC0; sec_base = 9'd0;
    end
    rem_c    = 6'(in_item.hue - sec_base);
    frac_mul = 10'(rem_c) * 10'd17;        // rem * 255 / 60 == rem * 17 / 4
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_sat    <= sat_mul[26:19];
      s1_val    <= val_mul[26:19];
      s1_frac   <= frac_mul[9:2];
      s1_sector <= sec_c;
      s1_blank  <= in_item.blank;
    end
  end

  // stage 2: saturation times fraction and complement
  logic [15:0] s2_sf, s2_sfc;
  logic [7:0]  s2_pa, s2_val;
  logic [2:0]  s2_sector;
  logic        s2_blank;

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_sf     <= 16'(s1_sat) * 16'(s1_frac);
      s2_sfc    <= 16'(s1_sat) * 16'(8'd255 - s1_frac);
      s2_pa     <= 8'd255 - s1_sat;
      s2_val    <= s1_val;
      s2_sector <= s1_sector;
      s2_blank  <= s1_blank;
    end
  end

  // stage 3: divide by 255 and complement
  logic [7:0] s3_pa, s3_qa, s3_ta, s3_val;
  logic [2:0] s3_sector;
  logic       s3_blank;

  always_ff @(posedge clk) begin
    if (en3) begin
      s3_pa     <= s2_pa;
      s3_qa     <= 8'd255 - div255(s2_sf);
      s3_ta     <= 8'd255 - div255(s2_sfc);
      s3_val    <= s2_val;
      s3_sector <= s2_sector;
      s3_blank  <= s2_blank;
    end
  end

  // stage 4: value products
  logic [15:0] s4_pv, s4_qv, s4_tv;
  logic [7:0]  s4_val;
  logic [2:0]  s4_sector;
  logic        s4_blank;

  always_ff @(posedge clk) begin
    if (en4) begin
      s4_pv     <= 16'(s3_val) * 16'(s3_pa);
      s4_qv     <= 16'(s3_val) * 16'(s3_qa);
      s4_tv     <= 16'(s3_val) * 16'(s3_ta);
      s4_val    <= s3_val;
      s4_sector <= s3_sector;
      s4_blank  <= s3_blank;
    end
  end

  // stage 5: final divide, channel select, pack
  logic [7:0]  p_c, q_c, t_c, r_c, g_c, b_c;
  logic [15:0] color_c;

  always_comb begin
    p_c = div255(s4_pv);
    q_c = div255(s4_qv);
    t_c = div255(s4_tv);
    unique case (s4_sector)
      SEC0:    begin r_c = s4_val; g_c = t_c;    b_c = p_c;    end
      SEC1:    begin r_c = q_c;    g_c = s4_val; b_c = p_c;    end
      SEC2:    begin r_c = p_c;    g_c = s4_val; b_c = t_c;    end
      SEC3:    begin r_c = p_c;    g_c = q_c;    b_c = s4_val; end
      SEC4:    begin r_c = t_c;    g_c = p_c;    b_c = s4_val; end
      default: begin r_c = s4_val; g_c = p_c;    b_c = q_c;    end
    endcase
    color_c = s4_blank ? 16'd0 : {r_c[7:3], g_c[7:2], b_c[7:3]};
  end

  always_ff @(posedge clk) begin
    if (en5) begin
      color_565 <= color_c;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
      if (en5) v5 <= v4;
    end
  end

  assign out_valid = v5;

endmodule

FILE: rtl/core/hsv_palette_to_rgb565.sv
// ----------------------------------------------------------------------------
// hsv_palette_to_rgb565: palette role to RGB565 colour
// Derives a palette role's HSV from the configured base colour and scheme
// and converts it to packed RGB565.
// ----------------------------------------------------------------------------
//
//  channel   handshake               payload          direction
//  -------   ---------------------   --------------   ---------
//  in        in_valid / in_ready     role [3:0]       into block
//  out       out_valid / out_ready   color_565 [15:0] out of block
//  cfg       cfg_we                  cfg_index, cfg_data  into block
//
//  One transaction per cycle sustained while out_ready stays high. From input
//  acceptance to out_valid, the queue entry is written at the accepting edge,
//  then the five pipeline registers follow, the output register last.
//  Synchronous reset empties the queue and drops all in-flight transactions;
//  configuration registers return to hue 180, sat 255, val 255, scheme 2.
//  A stall on out backs up the pipeline; in_ready falls only once the
//  QUEUE_DEPTH-entry queue behind the front end fills.
//
module hsv_palette_to_rgb565
  import hsvp_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2   // 2..16 entries
) (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [8:0]  cfg_data,
  // request
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [3:0]  role,
  // result
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] color_565
);

  cfg_t  cfg;
  item_t front_item;
  item_t queue_item;
  logic  queue_full;
  logic  queue_avail;
  logic  queue_pop;
  logic  push;

  // Configuration registers; data above a register's width is dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.base_hue    <= 9'd180;
      cfg.base_sat    <= 8'd255;
      cfg.base_val    <= 8'd255;
      cfg.scheme_type <= 3'd2;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BASE_HUE:    cfg.base_hue    <= cfg_data;
        REG_BASE_SAT:    cfg.base_sat    <= cfg_data[7:0];
        REG_BASE_VAL:    cfg.base_val    <= cfg_data[7:0];
        REG_SCHEME_TYPE: cfg.scheme_type <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // Front end: classify role into hue and scaled sat/val.
  hsvp_front u_front (
    .role (role),
    .cfg  (cfg),
    .item (front_item)
  );

  assign in_ready = !queue_full;
  assign push     = in_valid && in_ready;

  hsvp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (front_item),
    .full      (queue_full),
    .not_empty (queue_avail),
    .pop       (queue_pop),
    .pop_item  (queue_item)
  );

  // Back end: HSV to RGB565 pipeline with its own stall chain.
  hsvp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (queue_avail),
    .in_item   (queue_item),
    .in_take   (queue_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .color_565 (color_565)
  );

endmodule

FILE: rtl/core/hsvp_checker.sv
// ----------------------------------------------------------------------------
// hsvp_checker: port-level checks for hsv_palette_to_rgb565
// Tracks outstanding transactions and checks reset and output behavior.
// ----------------------------------------------------------------------------
module hsvp_checker #(
  parameter int QUEUE_DEPTH = 2
) (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] color_565
);

  localparam int STAGES  = 5;
  localparam int MAX_OUT = QUEUE_DEPTH + STAGES;
  localparam int OUT_W   = $clog2(MAX_OUT + 2);

  logic [OUT_W-1:0] outstanding;
  logic             in_acc;
  logic             out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      outstanding <= '0;
    end else if (in_acc && !out_acc) begin
      outstanding <= OUT_W'(outstanding + 1'b1);
    end else if (out_acc && !in_acc) begin
      outstanding <= OUT_W'(outstanding - 1'b1);
    end
  end

  a_reset_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid high after reset");

  a_reset_ready: assert property (@(posedge clk) rst |=> in_ready)
    else $error("in_ready low after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(color_565))
    else $error("stalled result changed or dropped");

  a_no_invent: assert property (@(posedge clk) disable iff (rst)
    out_acc |-> (outstanding != '0) || in_acc)
    else $error("result without a pending request");

  a_bounded: assert property (@(posedge clk) disable iff (rst)
    outstanding <= OUT_W'(MAX_OUT))
    else $error("more transactions in flight than storage");

endmodule

bind hsv_palette_to_rgb565 hsvp_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_hsvp_checker (.*);
